// ===== rtl/maze_backtracker_generator_assert.svh =====
// Assertion macros used by the checker of the maze generator.
// Both sample on the rising edge of clk and stay quiet while arst_n is low.
`ifndef MAZE_BACKTRACKER_GENERATOR_ASSERT_SVH
`define MAZE_BACKTRACKER_GENERATOR_ASSERT_SVH

// Plain property check.
`define MBG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition in one cycle implies a condition in the next one.
`define MBG_ASSERT_NEXT(lbl, pre, post, msg) \
	`MBG_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// ===== rtl/mbg_pkg.sv =====
package mbg_pkg;

	localparam int MAP_DIM     = 32;
	localparam int STACK_DEPTH = 256;

	localparam int COORD_W    = $clog2(MAP_DIM);
	localparam int SP_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
	localparam int FIELD_W    = 5;
	localparam int SEED_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [SEED_W-1:0] LFSR_TAPS = 32'h8020_0003;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LFSR_SEED = 2'd0,
		CFG_START_COL = 2'd1,
		CFG_START_ROW = 2'd2
	} cfg_reg_t;

	typedef logic [MAP_DIM-1:0]   row_t;
	typedef logic [COORD_W-1:0]   coord_t;
	typedef logic [2*COORD_W-1:0] cell_t;

	typedef struct packed {
		logic [SEED_W-1:0]  seed;
		logic [FIELD_W-1:0] start_col;
		logic [FIELD_W-1:0] start_row;
	} cfg_t;

	// one read row, one masked write row per cycle
	typedef struct packed {
		coord_t rd_addr;
		logic   wr_en;
		coord_t wr_addr;
		row_t   wr_data;
		row_t   wr_mask;
	} map_req_t;

	typedef struct packed {
		logic [SP_W-1:0] rd_addr;
		logic            wr_en;
		logic [SP_W-1:0] wr_addr;
		cell_t           wr_data;
	} stack_req_t;

endpackage

// ===== rtl/mbg_wall_map.sv =====
module mbg_wall_map (
	input  logic              clk,
	input  mbg_pkg::map_req_t req,
	output mbg_pkg::row_t     rd_data
);
	import mbg_pkg::*;

	// one row of wall bits per word, 1 = wall
	row_t mem [MAP_DIM];

	always_ff @(posedge clk) begin
		rd_data <= mem[req.rd_addr];
		if (req.wr_en) begin
			for (int b = 0; b < MAP_DIM; b++) begin
				if (req.wr_mask[b]) begin
					mem[req.wr_addr][b] <= req.wr_data[b];
				end
			end
		end
	end

endmodule

// ===== rtl/mbg_cell_stack.sv =====
module mbg_cell_stack (
	input  logic                clk,
	input  mbg_pkg::stack_req_t req,
	output mbg_pkg::cell_t      rd_data
);
	import mbg_pkg::*;

	cell_t mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		rd_data <= mem[req.rd_addr];
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

endmodule

// ===== rtl/mbg_ctrl.sv =====
module mbg_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         restart,
	output logic                         busy,
	input  mbg_pkg::cfg_t                cfg,
	output mbg_pkg::map_req_t            map_req,
	input  mbg_pkg::row_t                map_rd_data,
	output mbg_pkg::stack_req_t          stk_req,
	input  mbg_pkg::cell_t               stk_rd_data,
	output logic                         done,
	output logic [mbg_pkg::FIELD_W-1:0]  cell_col,
	output logic [mbg_pkg::FIELD_W-1:0]  cell_row,
	output logic [mbg_pkg::FIELD_W-1:0]  gap_col,
	output logic [mbg_pkg::FIELD_W-1:0]  gap_row,
	output logic                         carved,
	output logic                         backtracked,
	output logic                         finished
);
	import mbg_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_TOP,
		ST_ROW_C,
		ST_ROW_P,
		ST_ROW_M,
		ST_PICK,
		ST_CUT_CELL,
		ST_CUT_GAP
	} state_t;

	typedef enum logic [1:0] {
		DIR_YP,
		DIR_YM,
		DIR_XP,
		DIR_XM
	} dir_t;

	localparam coord_t             LAST_IDX  = coord_t'(MAP_DIM - 1);
	localparam coord_t             TWO       = coord_t'(2);
	localparam coord_t             ONE       = coord_t'(1);
	localparam logic [COORD_W:0]   GRID_LIM  = (COORD_W + 1)'(MAP_DIM);
	localparam logic [CNT_W-1:0]   DEPTH_LIM = CNT_W'(STACK_DEPTH);

	function automatic logic [3:0] digit_sum(input logic [7:0] b);
		logic [3:0] s;
		s = '0;
		for (int i = 0; i < 4; i++) begin
			s = s + 4'(b[2*i +: 2]);
		end
		return s;
	endfunction

	// base-4 digit sums keep the residue mod 3
	function automatic logic [1:0] mod3_reduce(input logic [3:0] g0, input logic [3:0] g1,
			input logic [3:0] g2, input logic [3:0] g3);
		logic [5:0] s;
		logic [3:0] t;
		s = 6'(g0) + 6'(g1) + 6'(g2) + 6'(g3);
		t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
		if (t >= 4'd6) begin
			t = t - 4'd6;
		end else if (t >= 4'd3) begin
			t = t - 4'd3;
		end
		return t[1:0];
	endfunction

	function automatic dir_t nth_dir(input logic [3:0] avail, input logic [1:0] idx);
		dir_t       d;
		logic [1:0] seen;
		d    = DIR_YP;
		seen = '0;
		for (int i = 0; i < 4; i++) begin
			if (avail[i]) begin
				if (seen == idx) begin
					d = dir_t'(2'(i));
				end
				seen = seen + 2'd1;
			end
		end
		return d;
	endfunction

	state_t             state_q;
	coord_t             row_q;
	logic [CNT_W-1:0]   count_q;
	logic [SEED_W-1:0]  lfsr_q;
	logic [SEED_W-1:0]  pick_q;
	logic [3:0]         grp_q [4];
	logic [1:0]         mod3_q;
	coord_t             sx_q, sy_q;
	coord_t             cx_q, cy_q;
	logic               xp_q, xm_q, yp_q;
	dir_t               dir_q;
	coord_t             nx_q, ny_q, gx_q, gy_q;
	logic               done_q;
	logic [FIELD_W-1:0] cell_col_q, cell_row_q, gap_col_q, gap_row_q;
	logic               carved_q, backtracked_q, finished_q;

	logic [SEED_W-1:0]  lfsr_next_c;
	coord_t             sx_c, sy_c;
	logic [COORD_W:0]   cxp2_c, cyp2_c;
	logic               xp_ok_c, xm_ok_c, yp_ok_c, ym_ok_c;
	logic [3:0]         avail_c;
	logic [2:0]         n_c;
	logic [1:0]         idx_c;
	dir_t               dir_c;
	coord_t             nx_c, ny_c, gx_c, gy_c;

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign cell_col    = cell_col_q;
	assign cell_row    = cell_row_q;
	assign gap_col     = gap_col_q;
	assign gap_row     = gap_row_q;
	assign carved      = carved_q;
	assign backtracked = backtracked_q;
	assign finished    = finished_q;

	assign lfsr_next_c = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : '0);

	assign sx_c = (32'(cfg.start_col) >= 32'(MAP_DIM)) ? LAST_IDX : coord_t'(cfg.start_col);
	assign sy_c = (32'(cfg.start_row) >= 32'(MAP_DIM)) ? LAST_IDX : coord_t'(cfg.start_row);

	assign cxp2_c  = {1'b0, cx_q} + (COORD_W + 1)'(2);
	assign cyp2_c  = {1'b0, cy_q} + (COORD_W + 1)'(2);
	assign xp_ok_c = (cxp2_c < GRID_LIM) && map_rd_data[cxp2_c[COORD_W-1:0]];
	assign xm_ok_c = (cx_q >= TWO) && map_rd_data[cx_q - TWO];
	assign yp_ok_c = (cyp2_c < GRID_LIM) && map_rd_data[cx_q];
	assign ym_ok_c = (cy_q >= TWO) && map_rd_data[cx_q];

	// bit i follows the search order +y, -y, +x, -x
	assign avail_c = {xm_q, xp_q, ym_ok_c, yp_q};
	assign n_c     = 3'(avail_c[0]) + 3'(avail_c[1]) + 3'(avail_c[2]) + 3'(avail_c[3]);

	always_comb begin
		case (n_c)
			3'd1:    idx_c = 2'd0;
			3'd2:    idx_c = {1'b0, pick_q[0]};
			3'd3:    idx_c = mod3_q;
			default: idx_c = pick_q[1:0];
		endcase
	end

	assign dir_c = nth_dir(avail_c, idx_c);

	always_comb begin
		nx_c = cx_q;
		ny_c = cy_q;
		gx_c = cx_q;
		gy_c = cy_q;
		case (dir_c)
			DIR_YP: begin
				ny_c = cy_q + TWO;
				gy_c = cy_q + ONE;
			end
			DIR_YM: begin
				ny_c = cy_q - TWO;
				gy_c = cy_q - ONE;
			end
			DIR_XP: begin
				nx_c = cx_q + TWO;
				gx_c = cx_q + ONE;
			end
			default: begin
				nx_c = cx_q - TWO;
				gx_c = cx_q - ONE;
			end
		endcase
	end

	// memory requests
	always_comb begin
		map_req         = '0;
		stk_req         = '0;
		stk_req.rd_addr = count_q[SP_W-1:0];
		case (state_q)
			ST_CLEAR: begin
				map_req.wr_en   = 1'b1;
				map_req.wr_addr = row_q;
				map_req.wr_mask = '1;
				map_req.wr_data = '1;
				if (row_q == sy_q) begin
					map_req.wr_data[sx_q] = 1'b0;
				end
				if (row_q == LAST_IDX) begin
					stk_req.wr_en   = 1'b1;
					stk_req.wr_addr = '0;
					stk_req.wr_data = {sy_q, sx_q};
				end
			end
			ST_ROW_C: begin
				map_req.rd_addr = stk_rd_data[2*COORD_W-1:COORD_W];
			end
			ST_ROW_P: begin
				map_req.rd_addr = cy_q + TWO;
			end
			ST_ROW_M: begin
				map_req.rd_addr = cy_q - TWO;
			end
			ST_CUT_CELL: begin
				map_req.wr_en         = 1'b1;
				map_req.wr_addr       = ny_q;
				map_req.wr_mask[nx_q] = 1'b1;
				if (dir_q inside {DIR_XP, DIR_XM}) begin
					map_req.wr_mask[gx_q] = 1'b1;
				end
				if (count_q < DEPTH_LIM) begin
					stk_req.wr_en   = 1'b1;
					stk_req.wr_addr = count_q[SP_W-1:0];
					stk_req.wr_data = {ny_q, nx_q};
				end
			end
			ST_CUT_GAP: begin
				map_req.wr_en         = 1'b1;
				map_req.wr_addr       = gy_q;
				map_req.wr_mask[gx_q] = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			count_q <= '0;
			lfsr_q  <= SEED_W'(1);
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (restart) begin
							sx_q    <= sx_c;
							sy_q    <= sy_c;
							lfsr_q  <= (cfg.seed == '0) ? SEED_W'(1) : cfg.seed;
							count_q <= '0;
							row_q   <= '0;
							state_q <= ST_CLEAR;
						end else begin
							pick_q <= lfsr_q;
							lfsr_q <= lfsr_next_c;
							if (count_q == '0) begin
								done_q        <= 1'b1;
								cell_col_q    <= '0;
								cell_row_q    <= '0;
								gap_col_q     <= '0;
								gap_row_q     <= '0;
								carved_q      <= 1'b0;
								backtracked_q <= 1'b0;
								finished_q    <= 1'b1;
							end else begin
								count_q <= count_q - CNT_W'(1);
								state_q <= ST_TOP;
							end
						end
					end
				end
				ST_CLEAR: begin
					if (row_q == LAST_IDX) begin
						count_q       <= CNT_W'(1);
						done_q        <= 1'b1;
						cell_col_q    <= FIELD_W'(sx_q);
						cell_row_q    <= FIELD_W'(sy_q);
						gap_col_q     <= FIELD_W'(sx_q);
						gap_row_q     <= FIELD_W'(sy_q);
						carved_q      <= 1'b1;
						backtracked_q <= 1'b0;
						finished_q    <= 1'b0;
						state_q       <= ST_IDLE;
					end else begin
						row_q <= row_q + ONE;
					end
				end
				ST_TOP: begin
					for (int i = 0; i < 4; i++) begin
						grp_q[i] <= digit_sum(pick_q[8*i +: 8]);
					end
					state_q <= ST_ROW_C;
				end
				ST_ROW_C: begin
					cx_q    <= stk_rd_data[COORD_W-1:0];
					cy_q    <= stk_rd_data[2*COORD_W-1:COORD_W];
					mod3_q  <= mod3_reduce(grp_q[0], grp_q[1], grp_q[2], grp_q[3]);
					state_q <= ST_ROW_P;
				end
				ST_ROW_P: begin
					xp_q    <= xp_ok_c;
					xm_q    <= xm_ok_c;
					state_q <= ST_ROW_M;
				end
				ST_ROW_M: begin
					yp_q    <= yp_ok_c;
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					if (n_c == 3'd0) begin
						done_q        <= 1'b1;
						cell_col_q    <= '0;
						cell_row_q    <= '0;
						gap_col_q     <= '0;
						gap_row_q     <= '0;
						carved_q      <= 1'b0;
						backtracked_q <= 1'b1;
						finished_q    <= 1'b0;
						state_q       <= ST_IDLE;
					end else begin
						// popped entry still holds this cell: restore the count
						count_q <= count_q + CNT_W'(1);
						dir_q   <= dir_c;
						nx_q    <= nx_c;
						ny_q    <= ny_c;
						gx_q    <= gx_c;
						gy_q    <= gy_c;
						state_q <= ST_CUT_CELL;
					end
				end
				ST_CUT_CELL: begin
					if (count_q < DEPTH_LIM) begin
						count_q <= count_q + CNT_W'(1);
					end
					if (dir_q inside {DIR_XP, DIR_XM}) begin
						done_q        <= 1'b1;
						cell_col_q    <= FIELD_W'(nx_q);
						cell_row_q    <= FIELD_W'(ny_q);
						gap_col_q     <= FIELD_W'(gx_q);
						gap_row_q     <= FIELD_W'(gy_q);
						carved_q      <= 1'b1;
						backtracked_q <= 1'b0;
						finished_q    <= 1'b0;
						state_q       <= ST_IDLE;
					end else begin
						state_q <= ST_CUT_GAP;
					end
				end
				ST_CUT_GAP: begin
					done_q        <= 1'b1;
					cell_col_q    <= FIELD_W'(nx_q);
					cell_row_q    <= FIELD_W'(ny_q);
					gap_col_q     <= FIELD_W'(gx_q);
					gap_row_q     <= FIELD_W'(gy_q);
					carved_q      <= 1'b1;
					backtracked_q <= 1'b0;
					finished_q    <= 1'b0;
					state_q       <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/maze_backtracker_generator.sv =====
// Channel   Handshake                 Payload
// -------   -----------------------   ---------------------------------------------
// input     start & !busy             restart
// result    done (one-cycle strobe)   cell_col cell_row gap_col gap_row
//                                     carved backtracked finished
// config    cfg_we                    cfg_idx cfg_wdata
//
// A step beat pops the top cell from the stack, then reads three rows in turn
// through the single read port of the row-wide wall map; a top cell that
// backtracks answers after the pick, a sideways carve after the cell write and
// a carve up or down after the follow-up gap write. A step on an empty stack
// answers in the cycle after it is accepted. A restart refills the map one row
// per cycle before it answers. busy is low in the cycle of done, so the next
// beat may start there. Reset clears control state only; the wall map is not
// swept after reset because it is never read before a restart refills it. The
// receiver cannot stall: each result is shown for exactly one cycle.
module maze_backtracker_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            restart,
	input  logic                            cfg_we,
	input  logic [mbg_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [mbg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output logic                            done,
	output logic [mbg_pkg::FIELD_W-1:0]     cell_col,
	output logic [mbg_pkg::FIELD_W-1:0]     cell_row,
	output logic [mbg_pkg::FIELD_W-1:0]     gap_col,
	output logic [mbg_pkg::FIELD_W-1:0]     gap_row,
	output logic                            carved,
	output logic                            backtracked,
	output logic                            finished
);
	import mbg_pkg::*;

	cfg_t       cfg_q;
	map_req_t   map_req;
	row_t       map_rd_data;
	stack_req_t stk_req;
	cell_t      stk_rd_data;

	// Configuration registers, written by the user only while idle (left to the user);
	// they take the write directly; an index past the last register is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.seed      <= SEED_W'(1);
			cfg_q.start_col <= FIELD_W'(1);
			cfg_q.start_row <= FIELD_W'(1);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_LFSR_SEED: cfg_q.seed      <= cfg_wdata[SEED_W-1:0];
				CFG_START_COL: cfg_q.start_col <= cfg_wdata[FIELD_W-1:0];
				CFG_START_ROW: cfg_q.start_row <= cfg_wdata[FIELD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer: pops the top cell, probes its four neighbours, picks one with the
	// LFSR and writes the carved cells and the push back; a restart refills the map.
	mbg_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.restart     (restart),
		.busy        (busy),
		.cfg         (cfg_q),
		.map_req     (map_req),
		.map_rd_data (map_rd_data),
		.stk_req     (stk_req),
		.stk_rd_data (stk_rd_data),
		.done        (done),
		.cell_col    (cell_col),
		.cell_row    (cell_row),
		.gap_col     (gap_col),
		.gap_row     (gap_row),
		.carved      (carved),
		.backtracked (backtracked),
		.finished    (finished)
	);

	// Wall map: one grid row per word, bit-masked writes.
	mbg_wall_map u_wall_map (
		.clk     (clk),
		.req     (map_req),
		.rd_data (map_rd_data)
	);

	// Stack of packed {row, col} cell coordinates.
	mbg_cell_stack u_cell_stack (
		.clk     (clk),
		.req     (stk_req),
		.rd_data (stk_rd_data)
	);

endmodule

// ===== rtl/mbg_checker.sv =====
`include "maze_backtracker_generator_assert.svh"

module mbg_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            restart,
	input logic                            done,
	input logic [mbg_pkg::FIELD_W-1:0]     cell_col,
	input logic [mbg_pkg::FIELD_W-1:0]     cell_row,
	input logic [mbg_pkg::FIELD_W-1:0]     gap_col,
	input logic [mbg_pkg::FIELD_W-1:0]     gap_row,
	input logic                            carved,
	input logic                            backtracked,
	input logic                            finished
);

	`MBG_ASSERT(a_one_outcome, done |-> $onehot({carved, backtracked, finished}), "result carries not exactly one outcome flag")

	`MBG_ASSERT(a_quiet_coords, (done && !carved) |-> (cell_col == '0 && cell_row == '0 && gap_col == '0 && gap_row == '0), "backtrack or finish beat with nonzero coordinates")

	`MBG_ASSERT_NEXT(a_restart_busy, start && !busy && restart, busy, "restart beat did not start the map refill")

	`MBG_ASSERT(a_done_cause, done |-> ($past(busy) || $past(start)), "result strobe without work in flight")

endmodule

bind maze_backtracker_generator mbg_checker u_mbg_checker (.*);
